### hw/rtl/colorimeter_counts_to_xyz_assert.svh
// ----------------------------------------------------------------------------
// colorimeter counts to xyz: assertion macros
// Shared property forms for the converter checks.
// ----------------------------------------------------------------------------
`ifndef COLORIMETER_COUNTS_TO_XYZ_ASSERT_SVH
`define COLORIMETER_COUNTS_TO_XYZ_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CCX_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ccx check failed");

// next-cycle implication, checked out of reset
`define CCX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ccx check failed");

`endif

### hw/rtl/ccx_pkg.sv
// ----------------------------------------------------------------------------
// ccx_pkg
// Widths, reset values and register indexes of the count to xyz converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccx_pkg;

   localparam int CNT_W      = 16;
   localparam int RATIO_W    = 32;
   localparam int NM_W       = 16;
   localparam int XYZ_W      = 32;
   localparam int COEF_W     = 20;
   localparam int DARK_W     = 20;
   localparam int MAT_W      = 60;
   localparam int PRE_W      = 16;
   localparam int POST_W     = 20;
   localparam int PT_W       = 16;
   localparam int PROD_W     = 48;
   localparam int T_W        = 50;
   localparam int T_LO_W     = 25;
   localparam int PL_W       = T_LO_W + 1 + COEF_W;
   localparam int PH_W       = T_W - T_LO_W + COEF_W;
   localparam int CT_W       = T_W + COEF_W;
   localparam int ACC_W      = CT_W + 2;
   localparam int ACC_PART_W = 24;
   localparam int FP_LO_W    = ACC_PART_W + 1 + POST_W + 1;
   localparam int FP_HI_W    = ACC_W - 2 * ACC_PART_W + POST_W + 1;
   localparam int FIN_W      = ACC_W + POST_W + 1;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 60;

   localparam logic [PRE_W-1:0]  RATIO_GAIN_RESET = 16'd2000;
   localparam logic [POST_W-1:0] OUT_GAIN_RESET   = 20'd219365;
   localparam logic [PT_W-1:0]   PRECISION_RESET  = 16'd3500;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MATRIX_ROW0 = 3'd0,
      CSR_MATRIX_ROW1 = 3'd1,
      CSR_MATRIX_ROW2 = 3'd2,
      CSR_DARK        = 3'd3,
      CSR_RATIO_GAIN  = 3'd4,
      CSR_OUT_GAIN    = 3'd5,
      CSR_PRECISION   = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

### hw/rtl/ccx_div.sv
// ----------------------------------------------------------------------------
// ccx_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccx_div
   import ccx_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             advance,
   input  wire logic [CNT_W-1:0]                 thresh,
   input  wire logic [CNT_W-1:0]                 count,
   output logic      [CNT_W+FRAC_BITS-1:0]       quotient
);

   localparam int NUM_W = CNT_W + FRAC_BITS;

   logic [CNT_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [CNT_W-1:0] cnt_ff [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [CNT_W-1:0] rem_i;
      logic [NUM_W-1:0] nq_i;
      logic [CNT_W-1:0] cnt_i;
      logic [CNT_W:0]   trial;
      logic             fits;
      logic [CNT_W-1:0] rem_in;
      logic [NUM_W-1:0] nq_in;

      if (s == 0) begin : g_first
         assign rem_i = '0;
         assign nq_i  = {thresh, {FRAC_BITS{1'b0}}};
         assign cnt_i = count;
      end else begin : g_next
         assign rem_i = rem_ff[s-1];
         assign nq_i  = nq_ff[s-1];
         assign cnt_i = cnt_ff[s-1];
      end

      always_comb begin
         trial  = {rem_i, nq_i[NUM_W-1]};
         fits   = (trial >= {1'b0, cnt_i});
         rem_in = fits ? CNT_W'(trial - {1'b0, cnt_i}) : trial[CNT_W-1:0];
         // quotient bits shift in from the bottom as numerator bits leave
         nq_in  = {nq_i[NUM_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s] <= rem_in;
            nq_ff[s]  <= nq_in;
            cnt_ff[s] <= cnt_i;
         end
      end
   end

   assign quotient = nq_ff[NUM_W-1];

endmodule

`default_nettype wire

### hw/rtl/ccx_lane.sv
// ----------------------------------------------------------------------------
// ccx_lane
// One colour channel: ratio, next-pass multiplier and matrix column terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccx_lane
   import ccx_pkg::*;
#(
   parameter int RATIO_FRAC_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    advance,
   input  wire logic [CNT_W-1:0]        count,
   input  wire logic [CNT_W-1:0]        thresh,
   input  wire logic [PRE_W-1:0]        ratio_gain,
   input  wire logic [PT_W-1:0]         precision,
   input  wire logic [DARK_W-1:0]       dark,
   input  wire logic signed [COEF_W-1:0] coef [3],
   output logic      [RATIO_W-1:0]      ratio,
   output logic      [NM_W-1:0]         next_mult,
   output logic signed [CT_W-1:0]       col_term [3]
);

   localparam int NUM_W = CNT_W + RATIO_FRAC_BITS;

   logic [NUM_W-1:0] quo;
   logic [63:0]      quo_ext;
   logic [RATIO_W-1:0] q_in;

   logic [RATIO_W-1:0] q1_ff, q2_ff, q3_ff, q4_ff;
   logic [PROD_W-1:0]  pre_prod_ff, pt_prod_ff;
   logic [PROD_W-1:0]  nm_full;
   logic [NM_W-1:0]    nm_in, nm2_ff, nm3_ff, nm4_ff;
   logic signed [T_W-1:0] dark_ext, t_in, t_ff;
   logic [T_LO_W-1:0]  t_lo;
   logic signed [T_W-T_LO_W-1:0] t_hi;
   logic signed [PL_W-1:0] pl_ff [3];
   logic signed [PH_W-1:0] ph_ff [3];
   logic signed [CT_W-1:0] ct_ff [3];

   ccx_div #(.FRAC_BITS(RATIO_FRAC_BITS)) u_div (
      .clock    (clock),
      .advance  (advance),
      .thresh   (thresh),
      .count    (count),
      .quotient (quo)
   );

   always_comb begin
      quo_ext  = 64'(quo);
      q_in     = (|quo_ext[63:32]) ? '1 : quo_ext[RATIO_W-1:0];
      nm_full  = pt_prod_ff >> RATIO_FRAC_BITS;
      if (nm_full == '0) begin
         nm_in = NM_W'(1);
      end else if (nm_full > PROD_W'({NM_W{1'b1}})) begin
         nm_in = '1;
      end else begin
         nm_in = nm_full[NM_W-1:0];
      end
      // dark offset is Q.8, bring it up to the ratio fraction
      dark_ext = T_W'(signed'(dark)) <<< (RATIO_FRAC_BITS - 8);
      t_in     = $signed({2'b00, pre_prod_ff}) - dark_ext;
      t_lo     = t_ff[T_LO_W-1:0];
      t_hi     = signed'(t_ff[T_W-1:T_LO_W]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q1_ff       <= q_in;
         pre_prod_ff <= PROD_W'(ratio_gain) * PROD_W'(q_in);
         pt_prod_ff  <= PROD_W'(precision) * PROD_W'(q_in);
         q2_ff       <= q1_ff;
         nm2_ff      <= nm_in;
         t_ff        <= t_in;
         q3_ff       <= q2_ff;
         nm3_ff      <= nm2_ff;
         q4_ff       <= q3_ff;
         nm4_ff      <= nm3_ff;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      always_ff @(posedge clock) begin
         if (advance) begin
            pl_ff[r] <= $signed({1'b0, t_lo}) * coef[r];
            ph_ff[r] <= t_hi * coef[r];
            ct_ff[r] <= (CT_W'(ph_ff[r]) <<< T_LO_W) + CT_W'(pl_ff[r]);
         end
      end
      assign col_term[r] = ct_ff[r];
   end

   assign ratio     = q4_ff;
   assign next_mult = nm4_ff;

endmodule

`default_nettype wire

### hw/rtl/ccx_merge.sv
// ----------------------------------------------------------------------------
// ccx_merge
// Sums the three lane terms of one matrix row and applies the post-scale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccx_merge
   import ccx_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    advance,
   input  wire logic [POST_W-1:0]       out_gain,
   input  wire logic signed [CT_W-1:0]  term [3],
   output logic signed [FIN_W-1:0]      scaled
);

   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [POST_W:0]    ps;
   logic signed [FP_LO_W-1:0] p0_ff, p1_ff;
   logic signed [FP_HI_W-1:0] p2_ff;
   logic signed [FIN_W-1:0]   fin_ff;

   assign ps = $signed({1'b0, out_gain});

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff <= ACC_W'(term[0]) + ACC_W'(term[1]) + ACC_W'(term[2]);
         // accumulator split in three slices to keep multipliers narrow
         p0_ff  <= $signed({1'b0, acc_ff[ACC_PART_W-1:0]}) * ps;
         p1_ff  <= $signed({1'b0, acc_ff[2*ACC_PART_W-1:ACC_PART_W]}) * ps;
         p2_ff  <= signed'(acc_ff[ACC_W-1:2*ACC_PART_W]) * ps;
         fin_ff <= (FIN_W'(p2_ff) <<< (2 * ACC_PART_W))
                 + (FIN_W'(p1_ff) <<< ACC_PART_W)
                 + FIN_W'(p0_ff);
      end
   end

   assign scaled = fin_ff;

endmodule

`default_nettype wire

### hw/rtl/colorimeter_counts_to_xyz.sv
// ----------------------------------------------------------------------------
// colorimeter_counts_to_xyz
// Raw colour counts to ratios, next-pass multipliers and saturated XYZ.
// ----------------------------------------------------------------------------
// Takes one word of three counts and three thresholds per clock and returns
// one result word per input word, in order. Each word passes through the
// per-channel divider (one quotient bit per stage), four lane stages for
// scaling and the matrix products, three merge stages for the row sum and
// post-scale, and the output register. The whole pipeline holds while a
// result waits and rsp_stall is high; a new word is accepted every cycle
// otherwise. A zero count sets div_error and zeroes every other field. The
// user must write registers through the csr port only while the block is
// empty; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "colorimeter_counts_to_xyz_assert.svh"

module colorimeter_counts_to_xyz
   import ccx_pkg::*;
#(
   parameter int COEF_FRAC_BITS  = 16,
   parameter int RATIO_FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wen,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CNT_W-1:0]      req_count_red,
   input  wire logic [CNT_W-1:0]      req_count_green,
   input  wire logic [CNT_W-1:0]      req_count_blue,
   input  wire logic [CNT_W-1:0]      req_thresh_red,
   input  wire logic [CNT_W-1:0]      req_thresh_green,
   input  wire logic [CNT_W-1:0]      req_thresh_blue,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [RATIO_W-1:0]         rsp_ratio_red,
   output logic [RATIO_W-1:0]         rsp_ratio_green,
   output logic [RATIO_W-1:0]         rsp_ratio_blue,
   output logic signed [XYZ_W-1:0]    rsp_xyz_x,
   output logic signed [XYZ_W-1:0]    rsp_xyz_y,
   output logic signed [XYZ_W-1:0]    rsp_xyz_z,
   output logic [NM_W-1:0]            rsp_next_mult_red,
   output logic [NM_W-1:0]            rsp_next_mult_green,
   output logic [NM_W-1:0]            rsp_next_mult_blue,
   output logic                       rsp_div_error
);

   localparam int LANE_LAT  = CNT_W + RATIO_FRAC_BITS + 4;
   localparam int MERGE_LAT = 3;
   localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;
   localparam int SHIFT_K   = RATIO_FRAC_BITS + COEF_FRAC_BITS + 8;

   logic [MAT_W-1:0]  matrix_ff [3];
   logic [MAT_W-1:0]  dark_ff;
   logic [PRE_W-1:0]  ratio_gain_ff;
   logic [POST_W-1:0] out_gain_ff;
   logic [PT_W-1:0]   precision_ff;

   logic advance;
   logic [PIPE_LAT-1:0] valid_ff;
   logic [PIPE_LAT-1:0] err_ff;

   logic [CNT_W-1:0] counts [3];
   logic [CNT_W-1:0] threshs [3];
   logic [RATIO_W-1:0] lane_ratio [3];
   logic [NM_W-1:0]    lane_nm [3];
   logic signed [CT_W-1:0] lane_ct [3][3];
   logic signed [CT_W-1:0] row_terms [3][3];
   logic signed [FIN_W-1:0] row_scaled [3];
   logic [RATIO_W-1:0] ratio_dly_ff [3][MERGE_LAT];
   logic [NM_W-1:0]    nm_dly_ff [3][MERGE_LAT];
   logic [XYZ_W-1:0]   xyz_sat [3];

   logic                    rsp_valid_ff;
   logic [RATIO_W-1:0]      rsp_ratio_ff [3];
   logic [XYZ_W-1:0]        rsp_xyz_ff [3];
   logic [NM_W-1:0]         rsp_nm_ff [3];
   logic                    rsp_err_ff;

   function automatic logic [XYZ_W-1:0] saturate(input logic signed [FIN_W-1:0] v);
      logic signed [FIN_W-1:0] s;
      logic [FIN_W-XYZ_W:0]    top;
      s   = v >>> SHIFT_K;
      top = s[FIN_W-1:XYZ_W-1];
      if (top == '0 || top == '1) begin
         saturate = s[XYZ_W-1:0];
      end else if (s[FIN_W-1]) begin
         saturate = {1'b1, {(XYZ_W-1){1'b0}}};
      end else begin
         saturate = {1'b0, {(XYZ_W-1){1'b1}}};
      end
   endfunction

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff[0]  <= '0;
         matrix_ff[1]  <= '0;
         matrix_ff[2]  <= '0;
         dark_ff       <= '0;
         ratio_gain_ff <= RATIO_GAIN_RESET;
         out_gain_ff   <= OUT_GAIN_RESET;
         precision_ff  <= PRECISION_RESET;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_MATRIX_ROW0: matrix_ff[0]  <= csr_wdata[MAT_W-1:0];
            CSR_MATRIX_ROW1: matrix_ff[1]  <= csr_wdata[MAT_W-1:0];
            CSR_MATRIX_ROW2: matrix_ff[2]  <= csr_wdata[MAT_W-1:0];
            CSR_DARK:        dark_ff       <= csr_wdata[MAT_W-1:0];
            CSR_RATIO_GAIN:  ratio_gain_ff <= csr_wdata[PRE_W-1:0];
            CSR_OUT_GAIN:    out_gain_ff   <= csr_wdata[POST_W-1:0];
            CSR_PRECISION:   precision_ff  <= csr_wdata[PT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // whole pipe moves together, held only by a waiting result word
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[PIPE_LAT-2:0], req_valid};
         rsp_valid_ff <= valid_ff[PIPE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err_ff <= {err_ff[PIPE_LAT-2:0],
                    (req_count_red == '0) || (req_count_green == '0)
                    || (req_count_blue == '0)};
      end
   end

   assign counts[0]  = req_count_red;
   assign counts[1]  = req_count_green;
   assign counts[2]  = req_count_blue;
   assign threshs[0] = req_thresh_red;
   assign threshs[1] = req_thresh_green;
   assign threshs[2] = req_thresh_blue;

   for (genvar j = 0; j < 3; j++) begin : g_lane
      logic signed [COEF_W-1:0] coefs [3];
      for (genvar r = 0; r < 3; r++) begin : g_coef
         assign coefs[r]        = signed'(matrix_ff[r][COEF_W*j +: COEF_W]);
         assign row_terms[r][j] = lane_ct[j][r];
      end

      ccx_lane #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_lane (
         .clock      (clock),
         .advance    (advance),
         .count      (counts[j]),
         .thresh     (threshs[j]),
         .ratio_gain (ratio_gain_ff),
         .precision  (precision_ff),
         .dark       (dark_ff[DARK_W*j +: DARK_W]),
         .coef       (coefs),
         .ratio      (lane_ratio[j]),
         .next_mult  (lane_nm[j]),
         .col_term   (lane_ct[j])
      );

      // line up ratio and multiplier with the merge stages
      always_ff @(posedge clock) begin
         if (advance) begin
            ratio_dly_ff[j][0] <= lane_ratio[j];
            nm_dly_ff[j][0]    <= lane_nm[j];
            for (int d = 1; d < MERGE_LAT; d++) begin
               ratio_dly_ff[j][d] <= ratio_dly_ff[j][d-1];
               nm_dly_ff[j][d]    <= nm_dly_ff[j][d-1];
            end
         end
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      ccx_merge u_merge (
         .clock    (clock),
         .advance  (advance),
         .out_gain (out_gain_ff),
         .term     (row_terms[r]),
         .scaled   (row_scaled[r])
      );
      assign xyz_sat[r] = saturate(row_scaled[r]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_err_ff <= err_ff[PIPE_LAT-1];
         for (int c = 0; c < 3; c++) begin
            rsp_ratio_ff[c] <= err_ff[PIPE_LAT-1] ? '0 : ratio_dly_ff[c][MERGE_LAT-1];
            rsp_nm_ff[c]    <= err_ff[PIPE_LAT-1] ? '0 : nm_dly_ff[c][MERGE_LAT-1];
            rsp_xyz_ff[c]   <= err_ff[PIPE_LAT-1] ? '0 : xyz_sat[c];
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ratio_red       = rsp_ratio_ff[0];
   assign rsp_ratio_green     = rsp_ratio_ff[1];
   assign rsp_ratio_blue      = rsp_ratio_ff[2];
   assign rsp_xyz_x           = signed'(rsp_xyz_ff[0]);
   assign rsp_xyz_y           = signed'(rsp_xyz_ff[1]);
   assign rsp_xyz_z           = signed'(rsp_xyz_ff[2]);
   assign rsp_next_mult_red   = rsp_nm_ff[0];
   assign rsp_next_mult_green = rsp_nm_ff[1];
   assign rsp_next_mult_blue  = rsp_nm_ff[2];
   assign rsp_div_error       = rsp_err_ff;

   `CCX_ASSERT_NOW(a_err_zeroes, rsp_valid_ff && rsp_err_ff,
      rsp_ratio_ff[0] == '0 && rsp_nm_ff[1] == '0 && rsp_xyz_ff[2] == '0)
   `CCX_ASSERT_NOW(a_nm_nonzero, rsp_valid_ff && !rsp_err_ff,
      rsp_nm_ff[0] != '0 && rsp_nm_ff[1] != '0 && rsp_nm_ff[2] != '0)
   `CCX_ASSERT_NOW(a_empty_takes, !rsp_valid_ff, !req_stall)
   `CCX_ASSERT_NEXT(a_drain, rsp_valid_ff && !rsp_stall && !valid_ff[PIPE_LAT-1],
      !rsp_valid_ff)

endmodule

`default_nettype wire
